// ----- design/dcpc_pkg.sv -----
`timescale 1ns / 1ps
package dcpc_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_MAN_ON = 2'd1,
    CMD_MAN_OFF = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_OFF = 2'd0,
    PH_ON = 2'd1,
    PH_PAUSE = 2'd2,
    PH_COOL = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_AUTO = 2'd1,
    SRC_MANUAL = 2'd2,
    SRC_RSVD = 2'd3
  } source_t;

  typedef enum logic [2:0] {
    REG_LATCH = 3'd0,
    REG_WINDOW = 3'd1,
    REG_PULSE_ON = 3'd2,
    REG_PULSE_OFF = 3'd3,
    REG_COOLDOWN = 3'd4,
    REG_BURST = 3'd5
  } reg_idx_t;

  localparam int CfgWidth = 24;
  localparam int DivSteps = 40;
  localparam logic [6:0] PctMax = 7'd100;

  typedef struct packed {
    logic sample;
    logic man_on;
    logic man_off;
    logic div_start;
    logic [1:0] div_probe;
    logic div_store;
    logic win_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic win_done;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- design/dcpc_ctrl.sv -----
`timescale 1ns / 1ps
module dcpc_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  logic [1:0] in_cmd,
  output dcpc_pkg::dp_cmd_t cmd_o,
  input  dcpc_pkg::dp_stat_t stat_i
);
  import dcpc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV = 5'b00010,
    S_WAIT = 5'b00100,
    S_NEXT = 5'b01000,
    S_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] probe_r, probe_nxt;
  logic accept;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign accept = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    probe_nxt = probe_r;
    cmd_o = '0;
    cmd_o.div_probe = probe_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_o.sample = (in_cmd == CMD_SAMPLE);
          cmd_o.man_on = (in_cmd == CMD_MAN_ON);
          cmd_o.man_off = (in_cmd == CMD_MAN_OFF);
          probe_nxt = 2'd0;
          state_nxt = ((in_cmd == CMD_SAMPLE) && stat_i.win_done) ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (probe_r == 2'd2) begin
          cmd_o.win_clear = 1'b1;
          state_nxt = S_OUT;
        end else begin
          probe_nxt = probe_r + 2'd1;
          state_nxt = S_DIV;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      probe_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      probe_r <= probe_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_probe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.div_start |-> (probe_r == 2'd0 || probe_r == 2'd1 || probe_r == 2'd2))
    else $error("bad probe index");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("accept during result");
endmodule

// ----- design/dcpc_datapath.sv -----
`timescale 1ns / 1ps
module dcpc_datapath #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [31:0] in_now_ms,
  input  logic in_fwd_wet,
  input  logic in_mid_wet,
  input  logic in_rear_wet,
  input  dcpc_pkg::dp_cmd_t cmd_i,
  output dcpc_pkg::dp_stat_t stat_o,
  output logic out_pump_on,
  output logic [1:0] out_pump_phase,
  output logic [1:0] out_run_source,
  output logic [7:0] out_cycle_number,
  output logic [2:0] out_latched_mask,
  output logic [31:0] out_fwd_hits,
  output logic [31:0] out_mid_hits,
  output logic [31:0] out_rear_hits,
  output logic [6:0] out_fwd_duty,
  output logic [6:0] out_mid_duty,
  output logic [6:0] out_rear_duty
);
  import dcpc_pkg::*;

  localparam int CW = COUNTER_WIDTH;
  localparam int NumW = CW + 7;
  localparam int StepW = $clog2(NumW + 1);

  logic [23:0] latch_ms_r, window_ms_r, on_ms_r, off_ms_r, cool_ms_r;
  logic [7:0] burst_r;
  logic [31:0] latch_until_r [3];
  logic [2:0] latched_r;
  logic [CW-1:0] hits_r [3];
  logic [CW-1:0] wet_r [3];
  logic [6:0] duty_r [3];
  logic [CW-1:0] win_cnt_r;
  logic [31:0] win_start_r;
  phase_t phase_r;
  source_t source_r;
  logic [7:0] cycle_r;
  logic [31:0] phase_start_r;

  logic [NumW-1:0] rem_r, quo_r;
  logic [NumW-1:0] num_nxt;
  logic [CW-1:0] den_r;
  logic [StepW-1:0] step_r;
  logic busy_r;
  logic [NumW:0] trial;
  logic [NumW-1:0] shifted;

  logic [2:0] wet_in;
  logic [31:0] el;
  logic [31:0] sd [3];
  logic [2:0] lat_new;
  logic [CW-1:0] win_inc;

  assign wet_in = {in_rear_wet, in_mid_wet, in_fwd_wet};
  assign win_inc = win_cnt_r + 1'b1;
  assign el = in_now_ms - phase_start_r;
  assign stat_o.win_done = (in_now_ms - win_start_r) >= {8'd0, window_ms_r};
  assign stat_o.div_done = busy_r && (step_r == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sd[k] = (wet_in[k] ? (in_now_ms + {8'd0, latch_ms_r}) : latch_until_r[k]) - in_now_ms;
      lat_new[k] = wet_in[k] || (sd[k] != 32'd0 && !sd[k][31]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_ms_r <= 24'd2000;
      window_ms_r <= 24'd60000;
      on_ms_r <= 24'd15000;
      off_ms_r <= 24'd5000;
      cool_ms_r <= 24'd300000;
      burst_r <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LATCH: latch_ms_r <= cfg_data;
        REG_WINDOW: window_ms_r <= cfg_data;
        REG_PULSE_ON: on_ms_r <= cfg_data;
        REG_PULSE_OFF: off_ms_r <= cfg_data;
        REG_COOLDOWN: cool_ms_r <= cfg_data;
        REG_BURST: burst_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Restoring divider: (100*wet + cnt/2) / cnt, one quotient bit per cycle.
  always_comb begin
    num_nxt = 7'd100 * {7'd0, wet_r[cmd_i.div_probe]} + {8'd0, win_cnt_r[CW-1:1]};
    shifted = {rem_r[NumW-2:0], quo_r[NumW-1]};
    trial = {1'b0, shifted} - {{(NumW-CW+1){1'b0}}, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (cmd_i.div_start) begin
      busy_r <= 1'b1;
      step_r <= StepW'(NumW);
      quo_r <= num_nxt;
      rem_r <= '0;
      den_r <= win_cnt_r;
    end else if (busy_r && step_r != '0) begin
      step_r <= step_r - 1'b1;
      if (!trial[NumW]) begin
        rem_r <= trial[NumW-1:0];
        quo_r <= {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[NumW-2:0], 1'b0};
      end
    end else if (cmd_i.div_store) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        latch_until_r[k] <= '0;
        hits_r[k] <= '0;
        wet_r[k] <= '0;
        duty_r[k] <= '0;
      end
      latched_r <= '0;
      win_cnt_r <= '0;
      win_start_r <= '0;
      phase_r <= PH_OFF;
      source_r <= SRC_NONE;
      cycle_r <= '0;
      phase_start_r <= '0;
    end else begin
      if (cmd_i.sample) begin
        for (int k = 0; k < 3; k++) begin
          if (wet_in[k]) begin
            latch_until_r[k] <= in_now_ms + {8'd0, latch_ms_r};
            wet_r[k] <= wet_r[k] + 1'b1;
          end
          if (lat_new[k] && !latched_r[k]) hits_r[k] <= hits_r[k] + 1'b1;
        end
        latched_r <= lat_new;
        win_cnt_r <= win_inc;
        if (stat_o.win_done) win_start_r <= in_now_ms;
        if (source_r == SRC_MANUAL) begin
          if (phase_r == PH_ON && el >= {8'd0, on_ms_r}) begin
            phase_r <= PH_PAUSE;
            phase_start_r <= in_now_ms;
          end else if (phase_r == PH_PAUSE && el >= {8'd0, off_ms_r}) begin
            cycle_r <= cycle_r + 8'd1;
            phase_r <= PH_ON;
            phase_start_r <= in_now_ms;
          end
        end else begin
          unique case (phase_r)
            PH_OFF: begin
              if (in_rear_wet) begin
                source_r <= SRC_AUTO;
                cycle_r <= 8'd1;
                phase_r <= PH_ON;
                phase_start_r <= in_now_ms;
              end
            end
            PH_ON: begin
              if (el >= {8'd0, on_ms_r}) begin
                phase_r <= PH_PAUSE;
                phase_start_r <= in_now_ms;
              end
            end
            PH_PAUSE: begin
              if (el >= {8'd0, off_ms_r}) begin
                if (cycle_r < burst_r) begin
                  cycle_r <= cycle_r + 8'd1;
                  phase_r <= PH_ON;
                end else begin
                  phase_r <= PH_COOL;
                end
                phase_start_r <= in_now_ms;
              end
            end
            PH_COOL: begin
              if (el >= {8'd0, cool_ms_r}) begin
                if (in_rear_wet) begin
                  cycle_r <= 8'd1;
                  phase_r <= PH_ON;
                  phase_start_r <= in_now_ms;
                end else begin
                  phase_r <= PH_OFF;
                  source_r <= SRC_NONE;
                  cycle_r <= 8'd0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (cmd_i.man_on) begin
        source_r <= SRC_MANUAL;
        cycle_r <= 8'd1;
        phase_r <= PH_ON;
        phase_start_r <= in_now_ms;
      end
      if (cmd_i.man_off) begin
        phase_r <= PH_OFF;
        source_r <= SRC_NONE;
        cycle_r <= 8'd0;
      end
      if (cmd_i.div_store) begin
        if (den_r == '0) duty_r[cmd_i.div_probe] <= 7'd0;
        else if (quo_r > NumW'(PctMax)) duty_r[cmd_i.div_probe] <= PctMax;
        else duty_r[cmd_i.div_probe] <= quo_r[6:0];
      end
      if (cmd_i.win_clear) begin
        for (int k = 0; k < 3; k++) wet_r[k] <= '0;
        win_cnt_r <= '0;
      end
    end
  end

  assign out_pump_on = (phase_r == PH_ON);
  assign out_pump_phase = phase_r;
  assign out_run_source = source_r;
  assign out_cycle_number = cycle_r;
  assign out_latched_mask = latched_r;
  assign out_fwd_hits = 32'(hits_r[0]);
  assign out_mid_hits = 32'(hits_r[1]);
  assign out_rear_hits = 32'(hits_r[2]);
  assign out_fwd_duty = duty_r[0];
  assign out_mid_duty = duty_r[1];
  assign out_rear_duty = duty_r[2];

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    duty_r[0] <= PctMax && duty_r[1] <= PctMax && duty_r[2] <= PctMax)
    else $error("duty out of range");
  a_pump: assert property (@(posedge clk) disable iff (!rst_n)
    (source_r == SRC_NONE) |-> (phase_r == PH_OFF))
    else $error("phase without source");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.win_clear |=> (win_cnt_r == '0))
    else $error("window not cleared");
endmodule

// ----- design/duty_cycled_pump_controller_top.sv -----
`timescale 1ns / 1ps
// Pump controller with three wet probes. Each input item carries a command
// (sample, manual on, manual off), a millisecond timestamp and three wet bits.
// Each accepted item yields exactly one result item with the pump state,
// latched probe view, rising-edge hit counts and last window duty percentages.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The configuration port writes one register per enabled cycle
// and the user must use it only while the block is idle; the block itself
// does not enforce this. An item that does not close the duty window shows
// its result in the cycle right after acceptance. An item that closes the
// window runs three divisions on one shared restoring divider, one quotient
// bit per cycle over COUNTER_WIDTH + 7 bits; each division is started, run
// and stored in turn (S_DIV, S_WAIT, S_NEXT) before the result is shown.
// One item is in work at a time; in_stall is high until the result is taken.
// While out_stall is high the result holds and no new item is accepted.
// Synchronous reset clears all counters and the sequencer and restores the
// register defaults.
module duty_cycled_pump_controller_top #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [23:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_cmd,
  input  logic [31:0] in_now_ms,
  input  logic in_fwd_wet,
  input  logic in_mid_wet,
  input  logic in_rear_wet,
  output logic out_valid,
  input  logic out_stall,
  output logic out_pump_on,
  output logic [1:0] out_pump_phase,
  output logic [1:0] out_run_source,
  output logic [7:0] out_cycle_number,
  output logic [2:0] out_latched_mask,
  output logic [31:0] out_fwd_hits,
  output logic [31:0] out_mid_hits,
  output logic [31:0] out_rear_hits,
  output logic [6:0] out_fwd_duty,
  output logic [6:0] out_mid_duty,
  output logic [6:0] out_rear_duty
);
  import dcpc_pkg::*;

  dp_cmd_t cmd;
  dp_stat_t stat;

  dcpc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .in_cmd(in_cmd), .cmd_o(cmd), .stat_i(stat)
  );

  dcpc_datapath #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_now_ms(in_now_ms), .in_fwd_wet(in_fwd_wet), .in_mid_wet(in_mid_wet),
    .in_rear_wet(in_rear_wet), .cmd_i(cmd), .stat_o(stat),
    .out_pump_on(out_pump_on), .out_pump_phase(out_pump_phase),
    .out_run_source(out_run_source), .out_cycle_number(out_cycle_number),
    .out_latched_mask(out_latched_mask), .out_fwd_hits(out_fwd_hits),
    .out_mid_hits(out_mid_hits), .out_rear_hits(out_rear_hits),
    .out_fwd_duty(out_fwd_duty), .out_mid_duty(out_mid_duty),
    .out_rear_duty(out_rear_duty)
  );
endmodule
